// ===== rtl/core/mlac_pkg.sv =====
// ----------------------------------------------------------------------------
// Mission leg advance checker package
// Item codes, leg word selectors, criterion codes, sequencer states and
// channel widths, leg limits and ALU operations shared by the leg advance checker.
// ----------------------------------------------------------------------------
package mlac_pkg;

   localparam int LEGS_DEFAULT = 16;
   localparam int RESULT_CAP   = 16;

   localparam int REQ_DATA_W = 232;
   localparam int RSP_DATA_W = 8;

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_TICK   = 2'd1;
   localparam logic [1:0] KIND_ACTION = 2'd2;

   localparam logic [2:0] SEL_CRIT    = 3'd0;
   localparam logic [2:0] SEL_TX      = 3'd1;
   localparam logic [2:0] SEL_TY      = 3'd2;
   localparam logic [2:0] SEL_TALT    = 3'd3;
   localparam logic [2:0] SEL_RADIUS  = 3'd4;
   localparam logic [2:0] SEL_TOL     = 3'd5;
   localparam logic [2:0] SEL_DWELL   = 3'd6;
   localparam logic [2:0] SEL_TIMEOUT = 3'd7;

   localparam logic [2:0] CRIT_ALWAYS   = 3'd0;
   localparam logic [2:0] CRIT_POSITION = 3'd1;
   localparam logic [2:0] CRIT_ALTITUDE = 3'd2;
   localparam logic [2:0] CRIT_TIME     = 3'd3;
   localparam logic [2:0] CRIT_IMAGE    = 3'd4;
   localparam logic [2:0] CRIT_MANUAL   = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_READ,
      ST_ELAPSED,
      ST_TIMEOUT,
      ST_DWELL,
      ST_DX,
      ST_AX,
      ST_DY,
      ST_AY,
      ST_MXX,
      ST_MYY,
      ST_MRR,
      ST_CMP_POS,
      ST_DALT,
      ST_AALT,
      ST_CMP_ALT,
      ST_OUT
   } state_type;

   typedef enum logic {
      ALU_SUB,
      ALU_ADD
   } alu_op_type;

endpackage

// ===== rtl/core/mission_leg_advance_checker.sv =====
// ----------------------------------------------------------------------------
// Mission leg advance checker
// Keeps a table of mission legs and, on each tick, reports for every loaded
// leg whether it may advance, using one shared adder-subtractor and multiplier.
// ----------------------------------------------------------------------------
// The req channel carries write, tick and action items, told apart by
// req_tuser. A write or action item gives no result. A tick item walks legs
// 0 to the leg count less one, the count capped at the table depth, and
// returns one rsp item per leg, in order, with rsp_tlast on the final one;
// a leg count of zero gives none. Each leg passes the read, elapsed time,
// timeout, dwell and output steps; the altitude and radius criteria add
// difference, absolute value and compare steps, the radius one also
// multiply steps, all on the shared 64-bit adder-subtractor and 32 by 32
// multiplier. A leg whose timeout has expired skips the criterion steps.
// req_tready is low while a tick is being worked on. A stalled rsp item
// holds the sequencer in its output step until it is taken. Reset clears
// the leg count, all entry-time flags and all action flags at once; other
// leg words hold nothing defined until written. csr_we writes the leg
// count at any edge; it is meant to change only while the block is idle.
// ----------------------------------------------------------------------------
module mission_leg_advance_checker #(
   parameter int MAX_LEGS = mlac_pkg::LEGS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // leg_index, word_select, word_value, pos_x, pos_y, altitude, now_ns, pad
   input  logic [mlac_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_leg, can_advance, pad
   output logic [mlac_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [4:0]                      csr_wdata
);
   import mlac_pkg::*;

   localparam int LEG_DEPTH = (MAX_LEGS < RESULT_CAP) ? MAX_LEGS : RESULT_CAP;
   localparam int IDX_W     = (LEG_DEPTH > 1) ? $clog2(LEG_DEPTH) : 1;
   localparam int CNT_W     = $clog2(LEG_DEPTH + 1);

   logic [3:0]  leg_index;
   logic [2:0]  word_select;
   logic [63:0] word_value;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [31:0] altitude;
   logic [63:0] now_ns;

   assign leg_index   = req_tdata[3:0];
   assign word_select = req_tdata[6:4];
   assign word_value  = req_tdata[70:7];
   assign pos_x       = req_tdata[102:71];
   assign pos_y       = req_tdata[134:103];
   assign altitude    = req_tdata[166:135];
   assign now_ns      = req_tdata[230:167];

   logic [2:0]  mem_crit    [LEG_DEPTH];
   logic [31:0] mem_tx      [LEG_DEPTH];
   logic [31:0] mem_ty      [LEG_DEPTH];
   logic [31:0] mem_talt    [LEG_DEPTH];
   logic [31:0] mem_radius  [LEG_DEPTH];
   logic [31:0] mem_tol     [LEG_DEPTH];
   logic [63:0] mem_dwell   [LEG_DEPTH];
   logic [63:0] mem_timeout [LEG_DEPTH];
   logic [63:0] mem_entry   [LEG_DEPTH];

   logic [LEG_DEPTH-1:0] entry_set_ff;
   logic [LEG_DEPTH-1:0] action_ff;

   state_type   state_ff, state_in;
   logic [4:0]  leg_count_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] num_ff, num_in;
   logic [31:0] px_ff, px_in;
   logic [31:0] py_ff, py_in;
   logic [31:0] alt_ff, alt_in;
   logic [63:0] now_ff, now_in;

   logic [2:0]  rd_crit_ff;
   logic [31:0] rd_tx_ff;
   logic [31:0] rd_ty_ff;
   logic [31:0] rd_talt_ff;
   logic [31:0] rd_radius_ff;
   logic [31:0] rd_tol_ff;
   logic [63:0] rd_dwell_ff;
   logic [63:0] rd_timeout_ff;
   logic [63:0] rd_entry_ff;
   logic        rd_set_ff;
   logic        rd_action_ff;

   logic [63:0] elapsed_ff, elapsed_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] ax_ff, ax_in;
   logic [31:0] ay_ff, ay_in;
   logic        big_ff, big_in;
   logic        tout_ff, tout_in;
   logic        dwell_ok_ff, dwell_ok_in;
   logic        adv_ff, adv_in;

   alu_op_type  alu_op;
   logic [63:0] alu_a;
   logic [63:0] alu_b;
   logic [64:0] alu_res;
   logic        borrow;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_res;

   logic              req_accept;
   logic              wr_ok;
   logic [IDX_W-1:0]  widx;
   logic [IDX_W-1:0]  ridx;
   logic [CNT_W-1:0]  sat_count;
   logic [63:0]       entry_eff;
   logic              stamp;
   logic              last;

   assign req_accept = req_tvalid && req_tready;
   assign wr_ok      = 32'(leg_index) < MAX_LEGS;
   assign widx       = leg_index[IDX_W-1:0];
   assign ridx       = cnt_ff[IDX_W-1:0];
   assign sat_count  = (leg_count_ff > 5'(LEG_DEPTH)) ? CNT_W'(LEG_DEPTH)
                                                       : CNT_W'(leg_count_ff);
   assign entry_eff  = rd_set_ff ? rd_entry_ff : 64'd0;
   assign stamp      = (entry_eff == 64'd0);
   assign last       = (cnt_ff == CNT_W'(num_ff - 1'b1));

   assign alu_res = (alu_op == ALU_ADD) ? ({1'b0, alu_a} + {1'b0, alu_b})
                                        : ({1'b0, alu_a} - {1'b0, alu_b});
   assign borrow  = alu_res[64];
   assign mul_res = mul_a * mul_b;

   assign rsp_tdata = {3'b000, adv_ff, 4'(cnt_ff)};
   assign rsp_tlast = last;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == KIND_TICK) && (sat_count != '0)) begin
               state_in = ST_READ;
            end
         end
         ST_READ:    state_in = ST_ELAPSED;
         ST_ELAPSED: state_in = ST_TIMEOUT;
         ST_TIMEOUT: state_in = ST_DWELL;
         ST_DWELL: begin
            if (tout_ff) begin
               state_in = ST_OUT;
            end else if (rd_crit_ff == CRIT_POSITION) begin
               state_in = ST_DX;
            end else if (rd_crit_ff == CRIT_ALTITUDE) begin
               state_in = ST_DALT;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_DX:      state_in = ST_AX;
         ST_AX:      state_in = ST_DY;
         ST_DY:      state_in = ST_AY;
         ST_AY:      state_in = ST_MXX;
         ST_MXX:     state_in = ST_MYY;
         ST_MYY:     state_in = ST_MRR;
         ST_MRR:     state_in = ST_CMP_POS;
         ST_CMP_POS: state_in = ST_OUT;
         ST_DALT:    state_in = ST_AALT;
         ST_AALT:    state_in = ST_CMP_ALT;
         ST_CMP_ALT: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = last ? ST_IDLE : ST_READ;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      alu_op     = ALU_SUB;
      alu_a      = 64'd0;
      alu_b      = 64'd0;
      mul_a      = 32'd0;
      mul_b      = 32'd0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_ELAPSED: begin
            alu_a = now_ff;
            alu_b = stamp ? now_ff : entry_eff;
         end
         ST_TIMEOUT: begin
            alu_a = rd_timeout_ff;
            alu_b = elapsed_ff;
         end
         ST_DWELL: begin
            alu_a = rd_dwell_ff;
            alu_b = elapsed_ff;
         end
         ST_DX: begin
            alu_a = {{32{px_ff[31]}}, px_ff};
            alu_b = {{32{rd_tx_ff[31]}}, rd_tx_ff};
         end
         ST_DY: begin
            alu_a = {{32{py_ff[31]}}, py_ff};
            alu_b = {{32{rd_ty_ff[31]}}, rd_ty_ff};
         end
         ST_DALT: begin
            alu_a = {{32{alt_ff[31]}}, alt_ff};
            alu_b = {{32{rd_talt_ff[31]}}, rd_talt_ff};
         end
         ST_AX, ST_AY, ST_AALT: begin
            if (acc_ff[63]) begin
               alu_b = acc_ff;
            end else begin
               alu_a = acc_ff;
            end
         end
         ST_MXX: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         ST_MYY: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         ST_MRR: begin
            mul_a  = rd_radius_ff;
            mul_b  = rd_radius_ff;
            alu_op = ALU_ADD;
            alu_a  = acc_ff;
            alu_b  = prod_ff;
         end
         ST_CMP_POS: begin
            alu_a = acc_ff;
            alu_b = prod_ff;
         end
         ST_CMP_ALT: begin
            alu_a = acc_ff;
            alu_b = {{32{rd_tol_ff[31]}}, rd_tol_ff};
         end
         ST_OUT: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      cnt_in      = cnt_ff;
      num_in      = num_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      alt_in      = alt_ff;
      now_in      = now_ff;
      elapsed_in  = elapsed_ff;
      acc_in      = acc_ff;
      prod_in     = prod_ff;
      ax_in       = ax_ff;
      ay_in       = ay_ff;
      big_in      = big_ff;
      tout_in     = tout_ff;
      dwell_ok_in = dwell_ok_ff;
      adv_in      = adv_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == KIND_TICK)) begin
               cnt_in = '0;
               num_in = sat_count;
               px_in  = pos_x;
               py_in  = pos_y;
               alt_in = altitude;
               now_in = now_ns;
            end
         end
         ST_ELAPSED: elapsed_in = alu_res[63:0];
         ST_TIMEOUT: tout_in = (rd_timeout_ff != 64'd0) && borrow;
         ST_DWELL: begin
            dwell_ok_in = (rd_dwell_ff == 64'd0) || borrow;
            if (tout_ff) begin
               adv_in = 1'b1;
            end else begin
               case (rd_crit_ff)
                  CRIT_ALWAYS:   adv_in = 1'b1;
                  CRIT_POSITION: adv_in = 1'b0;
                  CRIT_ALTITUDE: adv_in = 1'b0;
                  CRIT_TIME:     adv_in = dwell_ok_in;
                  CRIT_IMAGE:    adv_in = rd_action_ff;
                  CRIT_MANUAL:   adv_in = rd_action_ff;
                  default:       adv_in = 1'b1;
               endcase
            end
         end
         ST_DX, ST_DY, ST_DALT, ST_AALT: acc_in = alu_res[63:0];
         ST_AX: begin
            ax_in  = alu_res[31:0];
            big_in = (alu_res[63:31] != 33'd0);
         end
         ST_AY: begin
            ay_in  = alu_res[31:0];
            big_in = big_ff || (alu_res[63:31] != 33'd0);
         end
         ST_MXX: prod_in = mul_res;
         ST_MYY: begin
            prod_in = mul_res;
            acc_in  = prod_ff;
         end
         ST_MRR: begin
            prod_in = mul_res;
            acc_in  = alu_res[63:0];
         end
         ST_CMP_POS: begin
            adv_in = !rd_radius_ff[31] && (rd_radius_ff != 32'd0) && !big_ff
                     && borrow && dwell_ok_ff;
         end
         ST_CMP_ALT: begin
            adv_in = !rd_tol_ff[31] && (rd_tol_ff != 32'd0) && borrow && dwell_ok_ff;
         end
         ST_OUT: begin
            if (rsp_tready && !last) begin
               cnt_in = CNT_W'(cnt_ff + 1'b1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         leg_count_ff <= 5'd0;
         entry_set_ff <= '0;
         action_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            leg_count_ff <= csr_wdata;
         end
         if (state_ff == ST_ELAPSED && stamp) begin
            entry_set_ff[ridx] <= 1'b1;
         end
         if (req_accept && wr_ok) begin
            if (req_tuser == KIND_WRITE && word_select == SEL_CRIT) begin
               entry_set_ff[widx] <= 1'b0;
               action_ff[widx]    <= 1'b0;
            end else if (req_tuser == KIND_ACTION) begin
               action_ff[widx] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      num_ff      <= num_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      alt_ff      <= alt_in;
      now_ff      <= now_in;
      elapsed_ff  <= elapsed_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      big_ff      <= big_in;
      tout_ff     <= tout_in;
      dwell_ok_ff <= dwell_ok_in;
      adv_ff      <= adv_in;
   end

   always_ff @(posedge clock) begin
      if (req_accept && wr_ok && req_tuser == KIND_WRITE) begin
         case (word_select)
            SEL_CRIT:    mem_crit[widx]    <= word_value[2:0];
            SEL_TX:      mem_tx[widx]      <= word_value[31:0];
            SEL_TY:      mem_ty[widx]      <= word_value[31:0];
            SEL_TALT:    mem_talt[widx]    <= word_value[31:0];
            SEL_RADIUS:  mem_radius[widx]  <= word_value[31:0];
            SEL_TOL:     mem_tol[widx]     <= word_value[31:0];
            SEL_DWELL:   mem_dwell[widx]   <= word_value;
            SEL_TIMEOUT: mem_timeout[widx] <= word_value;
            default: ;
         endcase
      end
      if (state_ff == ST_ELAPSED && stamp) begin
         mem_entry[ridx] <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_crit_ff    <= mem_crit[ridx];
         rd_tx_ff      <= mem_tx[ridx];
         rd_ty_ff      <= mem_ty[ridx];
         rd_talt_ff    <= mem_talt[ridx];
         rd_radius_ff  <= mem_radius[ridx];
         rd_tol_ff     <= mem_tol[ridx];
         rd_dwell_ff   <= mem_dwell[ridx];
         rd_timeout_ff <= mem_timeout[ridx];
         rd_entry_ff   <= mem_entry[ridx];
         rd_set_ff     <= entry_set_ff[ridx];
         rd_action_ff  <= action_ff[ridx];
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_next_leg: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (state_ff == ST_READ))
      else $error("tick ended before its final leg");

   a_leg_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (cnt_ff < num_ff))
      else $error("result for a leg beyond the leg count");

   a_empty_tick: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser == KIND_TICK && leg_count_ff == 5'd0) |=> req_tready)
      else $error("empty tick did not return to idle");

   a_entry_stamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TIMEOUT) |-> entry_set_ff[ridx])
      else $error("leg evaluated without an entry time");

endmodule
